>>> rtl/epf_pkg.sv
package epf_pkg;

	// Input word: one number to be scaled to an engineering prefix.
	typedef struct packed {
		logic [7:0]        base;
		logic signed [31:0] value;
		logic signed [7:0] exponent;
		logic [3:0]        precision;
	} in_t;

	// Result word.
	typedef struct packed {
		logic        negative;
		logic [9:0]  integer_part;
		logic [26:0] fraction;
		logic [3:0]  fraction_digits;
		logic [4:0]  prefix_index;
		logic        invalid;
	} out_t;

	// Bit-serial divider widths.
	localparam int DIVIDEND_W = 58;
	localparam int DIVISOR_W  = 32;
	localparam int QUO_W      = 27;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUO_W-1:0]     quo;
		logic [DIVISOR_W-1:0] rem;
	} div_res_t;

	typedef struct packed {
		logic        start;
		logic [26:0] value;
		logic [3:0]  digits;
	} strip_req_t;

	typedef struct packed {
		logic        done;
		logic [26:0] value;
		logic [3:0]  digits;
	} strip_res_t;

	// Base codes and prefix table limits.
	localparam logic [7:0] BASE_BIN  = 8'd2;
	localparam logic [7:0] BASE_SI   = 8'd10;
	localparam logic [3:0] STEP_BIN  = 4'd10;
	localparam logic [3:0] STEP_SI   = 4'd3;
	localparam logic [3:0] MAX_PREC  = 4'd8;
	localparam logic [4:0] ZERO_BIN  = 5'd0;
	localparam logic [4:0] ZERO_SI   = 5'd8;
	localparam logic [4:0] LAST_BIN  = 5'd8;
	localparam logic [4:0] LAST_SI   = 5'd16;
	// The exponent is biased to stay positive for the floored division by the step.
	localparam logic [9:0] EX_BIAS    = 10'd150;
	localparam logic [6:0] BIAS_Q_BIN = 7'd15;
	localparam logic [6:0] BIAS_Q_SI  = 7'd50;
	localparam logic [10:0] FULL_BIN  = 11'd1024;
	localparam logic [10:0] FULL_SI   = 11'd1000;

	// Exact division by five through the modular inverse.
	localparam logic [26:0] INV5     = 27'h4CCCCCD;
	localparam logic [26:0] DIV5_LIM = 27'd26843545;

	function automatic logic [26:0] pow10(input logic [3:0] n);
		logic [26:0] r;
		case (n)
			4'd0: r = 27'd1;
			4'd1: r = 27'd10;
			4'd2: r = 27'd100;
			4'd3: r = 27'd1000;
			4'd4: r = 27'd10000;
			4'd5: r = 27'd100000;
			4'd6: r = 27'd1000000;
			4'd7: r = 27'd10000000;
			4'd8: r = 27'd100000000;
			default: r = 27'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/epf_div.sv
module epf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  epf_pkg::div_req_t req,
	output epf_pkg::div_res_t res
);
	import epf_pkg::*;

	logic                 busy_q;
	logic [4:0]           cnt_q;
	logic [DIVISOR_W-1:0] d_q;
	logic [DIVISOR_W-1:0] r_q;
	logic [QUO_W-1:0]     sh_q;
	logic [DIVISOR_W:0]   trial;
	logic                 ge;

	// One quotient bit per cycle: shift in the next dividend bit and try a subtract.
	assign trial = {r_q, sh_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(QUO_W);
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// The quotient is known to fit, so the upper dividend bits start as the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q  <= req.divisor;
			r_q  <= {1'b0, req.dividend[DIVIDEND_W-1:QUO_W]};
			sh_q <= req.dividend[QUO_W-1:0];
		end else if (busy_q && cnt_q != 5'd0) begin
			r_q  <= ge ? DIVISOR_W'(trial - {1'b0, d_q}) : trial[DIVISOR_W-1:0];
			sh_q <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign res.done = busy_q && cnt_q == 5'd0;
	assign res.quo  = sh_q;
	assign res.rem  = r_q;

endmodule

>>> rtl/epf_strip.sv
module epf_strip (
	input  logic                clk,
	input  logic                arst_n,
	input  epf_pkg::strip_req_t req,
	output epf_pkg::strip_res_t res
);
	import epf_pkg::*;

	logic        busy_q;
	logic [26:0] val_q;
	logic [3:0]  dig_q;
	logic [26:0] half;
	logic [53:0] prod;
	logic [26:0] quot;
	logic        can;

	// A value ends in a decimal zero when it is even and its half is a multiple of five.
	assign half = {1'b0, val_q[26:1]};
	assign prod = half * INV5;
	assign quot = prod[26:0];
	assign can  = val_q != 27'd0 && !val_q[0] && quot <= DIV5_LIM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && !can) begin
			busy_q <= 1'b0;
		end
	end

	// Drop one trailing zero digit per cycle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			val_q <= req.value;
			dig_q <= req.digits;
		end else if (busy_q && can) begin
			val_q <= quot;
			dig_q <= dig_q - 4'd1;
		end
	end

	assign res.done   = busy_q && !can;
	assign res.value  = val_q;
	assign res.digits = (val_q == 27'd0) ? 4'd0 : dig_q;

endmodule

>>> rtl/engineering_prefix_formatter.sv
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid / in_ready | in_data   (epf_pkg::in_t)
// out     | output    | out_valid/out_ready | out_data  (epf_pkg::out_t)
//
// One word at a time; the time from acceptance to a valid result is set by the
// serial steps: a power search (one step per digit of the magnitude), three passes of
// the bit-serial divider (27 quotient bits each), up to nine multiply-by-base steps,
// up to eight multiply-by-ten steps and up to seven trailing-zero steps.
// A bad base or precision goes straight to the done state. The next word is taken in idle.
// Reset clears the sequencer and the output valid; no clearing pass.
// A result waiting on out_ready holds the finished word; a new word is taken meanwhile,
// and its result waits in the last state until the output register is free.
module engineering_prefix_formatter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  epf_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output epf_pkg::out_t out_data
);
	import epf_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_LOG   = 9'b000000010,
		S_MOD   = 9'b000000100,
		S_SCALE = 9'b000001000,
		S_DIV1  = 9'b000010000,
		S_MUL   = 9'b000100000,
		S_DIV2  = 9'b001000000,
		S_STRIP = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic               si_q;
	logic               neg_q;
	logic signed [7:0]  y_q;
	logic [3:0]         prec_q;
	logic [40:0]        mag_q;
	logic [31:0]        pw_q;
	logic [4:0]         dv_q;
	logic [4:0]         cnt_q;
	logic               up_q;
	logic [6:0]         qx_q;
	logic [9:0]         ipart_q;
	logic [57:0]        num_q;
	logic               carry_q;
	out_t               res_q;
	logic               out_valid_q;
	out_t               out_q;

	div_req_t           dreq;
	div_res_t           dres;
	strip_req_t         sreq;
	strip_res_t         sres;

	logic [31:0]        mag_in;
	logic               bad_in;
	logic [35:0]        pw_next;
	logic signed [9:0]  ex10;
	logic [9:0]         ex_b;
	logic signed [5:0]  dv2;
	logic               rnd;
	logic [26:0]        fp;
	logic [10:0]        ip1;
	logic signed [8:0]  idx_s;
	logic [4:0]         last_idx;

	epf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.res    (dres)
	);

	epf_strip u_strip (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.res    (sres)
	);

	// Input decode.
	assign mag_in = in_data.value[31] ? (~in_data.value + 32'd1) : in_data.value;
	assign bad_in = in_data.precision > MAX_PREC ||
		(in_data.base != BASE_BIN && in_data.base != BASE_SI);

	// Next power of the base during the digit-count search.
	assign pw_next = si_q ? (({4'b0, pw_q} << 3) + ({4'b0, pw_q} << 1)) : ({4'b0, pw_q} << 1);

	// Biased exponent of the leading digit, floored later by the step.
	assign ex10 = $signed({5'b0, dv_q}) + $signed({{2{y_q[7]}}, y_q});
	assign ex_b = 10'(ex10 + $signed(EX_BIAS));
	assign dv2  = $signed({1'b0, dv_q}) - $signed({2'b0, dres.rem[3:0]});

	// Round half up on the next fraction digit, then the carry into the integer part.
	assign rnd = {dres.rem, 1'b0} >= {1'b0, pw_q};
	assign fp  = dres.quo + 27'(rnd);
	assign ip1 = {1'b0, ipart_q} + 11'd1;

	// Prefix index from the floored exponent quotient.
	assign idx_s = $signed({2'b0, qx_q}) + $signed({8'b0, carry_q})
		+ $signed({4'b0, (si_q ? ZERO_SI : ZERO_BIN)})
		- $signed({2'b0, (si_q ? BIAS_Q_SI : BIAS_Q_BIN)});
	assign last_idx = si_q ? LAST_SI : LAST_BIN;

	// Requests to the shared divider and the zero stripper.
	always_comb begin
		dreq = '0;
		sreq = '0;
		case (state_q)
			S_LOG: begin
				if ({4'b0, pw_next} > {8'b0, mag_q[31:0]}) begin
					dreq.start    = 1'b1;
					dreq.dividend = {49'b0, ex_b[8:0]};
					dreq.divisor  = {28'b0, (si_q ? STEP_SI : STEP_BIN)};
				end
			end
			S_SCALE: begin
				if (cnt_q == 5'd0) begin
					dreq.start    = 1'b1;
					dreq.dividend = {17'b0, mag_q};
					dreq.divisor  = pw_q;
				end
			end
			S_MUL: begin
				if (cnt_q == 5'd0) begin
					dreq.start    = 1'b1;
					dreq.dividend = num_q;
					dreq.divisor  = pw_q;
				end
			end
			S_DIV2: begin
				if (dres.done) begin
					sreq.start  = 1'b1;
					sreq.value  = (fp == pow10(prec_q)) ? 27'd0 : fp;
					sreq.digits = prec_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= bad_in ? S_DONE : S_LOG;
					end
				end
				S_LOG: begin
					if (dreq.start) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (dres.done) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (cnt_q == 5'd0) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (dres.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (cnt_q == 5'd0) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (dres.done) begin
						state_q <= S_STRIP;
					end
				end
				S_STRIP: begin
					if (sres.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output valid is set when a finished word moves out and cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				si_q    <= in_data.base == BASE_SI;
				neg_q   <= in_data.value[31];
				y_q     <= in_data.exponent;
				prec_q  <= in_data.precision;
				mag_q   <= {9'b0, mag_in};
				pw_q    <= 32'd1;
				dv_q    <= 5'd0;
				carry_q <= 1'b0;
				res_q   <= '{invalid: 1'b1, default: '0};
			end
			S_LOG: begin
				if (!dreq.start) begin
					pw_q <= pw_next[31:0];
					dv_q <= dv_q + 5'd1;
				end
			end
			S_MOD: begin
				if (dres.done) begin
					qx_q <= dres.quo[6:0];
					if (dv2 < 0) begin
						pw_q  <= 32'd1;
						cnt_q <= 5'(-dv2);
						up_q  <= 1'b1;
					end else if (!si_q) begin
						pw_q  <= 32'd1 << dv2[4:0];
						cnt_q <= 5'd0;
						up_q  <= 1'b0;
					end else begin
						pw_q  <= 32'd1;
						cnt_q <= dv2[4:0];
						up_q  <= 1'b0;
					end
				end
			end
			S_SCALE: begin
				if (cnt_q != 5'd0) begin
					cnt_q <= cnt_q - 5'd1;
					if (up_q) begin
						mag_q <= si_q ? ((mag_q << 3) + (mag_q << 1)) : (mag_q << 1);
					end else begin
						pw_q <= si_q ? ((pw_q << 3) + (pw_q << 1)) : (pw_q << 1);
					end
				end
			end
			S_DIV1: begin
				if (dres.done) begin
					ipart_q <= dres.quo[9:0];
					num_q   <= {26'b0, dres.rem};
					cnt_q   <= {1'b0, prec_q};
				end
			end
			S_MUL: begin
				if (cnt_q != 5'd0) begin
					cnt_q <= cnt_q - 5'd1;
					num_q <= (num_q << 3) + (num_q << 1);
				end
			end
			S_DIV2: begin
				if (dres.done && fp == pow10(prec_q)) begin
					if (ip1 == (si_q ? FULL_SI : FULL_BIN)) begin
						ipart_q <= 10'd1;
						carry_q <= 1'b1;
					end else begin
						ipart_q <= ip1[9:0];
					end
				end
			end
			S_STRIP: begin
				if (sres.done) begin
					if (idx_s < 0 || idx_s > $signed({4'b0, last_idx})) begin
						res_q <= '{invalid: 1'b1, default: '0};
					end else begin
						res_q.negative        <= neg_q;
						res_q.integer_part    <= ipart_q;
						res_q.fraction        <= sres.value;
						res_q.fraction_digits <= sres.digits;
						res_q.prefix_index    <= idx_s[4:0];
						res_q.invalid         <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/epf_checker.sv
module epf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input epf_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input epf_pkg::out_t out_data
);
	import epf_pkg::*;

	// A waiting result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Only one word is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	// An invalid result carries nothing else.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.invalid |-> out_data.integer_part == 10'd0 &&
		out_data.fraction == 27'd0 && out_data.fraction_digits == 4'd0 &&
		out_data.prefix_index == 5'd0 && !out_data.negative)
		else $error("invalid result with nonzero fields");

	// A zero fraction prints no digits, and digit counts and the prefix index stay in range.
	a_frac_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.fraction == 27'd0) == (out_data.fraction_digits == 4'd0)) &&
		out_data.fraction_digits <= MAX_PREC && out_data.prefix_index <= LAST_SI)
		else $error("fraction digit count inconsistent");

endmodule

bind engineering_prefix_formatter epf_checker u_epf_checker (.*);
